// ----- rtl/core/arx_pkg.sv -----
`default_nettype none
package arx_pkg;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 18;
  localparam int DELAY_W  = 4;
  localparam int FRAC     = 14;
  localparam int PROD_W   = SAMPLE_W + COEF_W;

  localparam int FEEDBACK_TAPS_DEF = 3;
  localparam int INPUT_TAPS_DEF    = 3;
  localparam int MAX_DELAY_DEF     = 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic [DELAY_W-1:0]         delay_t;

  typedef struct packed {
    sample_t control_value;
    sample_t noise_sample;
  } in_item_t;

  typedef struct packed {
    sample_t output_value;
    logic    saturated;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // sequencer strobes to the datapath
  typedef struct packed {
    logic start;
    logic issue;
    logic finish;
  } ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/arx_in_if.sv -----
`default_nettype none
interface arx_in_if;
  logic             valid;
  logic             ready;
  arx_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/arx_out_if.sv -----
`default_nettype none
interface arx_out_if;
  logic              valid;
  logic              ready;
  arx_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/arx_regs.sv -----
`default_nettype none
module arx_regs #(
  parameter int FEEDBACK_TAPS = arx_pkg::FEEDBACK_TAPS_DEF,
  parameter int INPUT_TAPS    = arx_pkg::INPUT_TAPS_DEF,
  parameter int PAW           = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [PAW-1:0]   paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output arx_pkg::coef_t        fb_coef [FEEDBACK_TAPS],
  output arx_pkg::coef_t        in_coef [INPUT_TAPS],
  output arx_pkg::delay_t       delay
);

  localparam int IW  = PAW - 2;
  localparam int FBW = (FEEDBACK_TAPS > 1) ? $clog2(FEEDBACK_TAPS) : 1;
  localparam int IIW = (INPUT_TAPS > 1) ? $clog2(INPUT_TAPS) : 1;

  arx_pkg::coef_t  fb_coef_r [FEEDBACK_TAPS];
  arx_pkg::coef_t  in_coef_r [INPUT_TAPS];
  arx_pkg::delay_t delay_r;

  logic [IW-1:0]  idx;
  logic [IW-1:0]  in_off;
  logic [FBW-1:0] fb_sel;
  logic [IIW-1:0] in_sel;
  logic           wr;

  assign idx    = paddr[PAW-1:2];
  assign in_off = IW'(idx - IW'(FEEDBACK_TAPS));
  assign fb_sel = idx[FBW-1:0];
  assign in_sel = in_off[IIW-1:0];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FEEDBACK_TAPS; i++) fb_coef_r[i] <= '0;
      for (int i = 0; i < INPUT_TAPS; i++) in_coef_r[i] <= '0;
      delay_r <= '0;
    end else if (wr) begin
      if (int'(idx) < FEEDBACK_TAPS) begin
        fb_coef_r[fb_sel] <= pwdata[arx_pkg::COEF_W-1:0];
      end else if (int'(idx) < FEEDBACK_TAPS + INPUT_TAPS) begin
        in_coef_r[in_sel] <= pwdata[arx_pkg::COEF_W-1:0];
      end else if (int'(idx) == FEEDBACK_TAPS + INPUT_TAPS) begin
        delay_r <= pwdata[arx_pkg::DELAY_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (int'(idx) < FEEDBACK_TAPS) begin
      prdata = 32'(fb_coef_r[fb_sel]);
    end else if (int'(idx) < FEEDBACK_TAPS + INPUT_TAPS) begin
      prdata = 32'(in_coef_r[in_sel]);
    end else if (int'(idx) == FEEDBACK_TAPS + INPUT_TAPS) begin
      prdata = 32'(delay_r);
    end
  end

  assign fb_coef = fb_coef_r;
  assign in_coef = in_coef_r;
  assign delay   = delay_r;

endmodule
`default_nettype wire

// ----- rtl/core/arx_hist.sv -----
`default_nettype none
module arx_hist #(
  parameter int DEPTH = arx_pkg::MAX_DELAY_DEF + arx_pkg::INPUT_TAPS_DEF,
  parameter int AW    = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire arx_pkg::sample_t  wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_off,
  output arx_pkg::sample_t       rd_data
);

  arx_pkg::sample_t mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [AW-1:0]    wp_r;
  logic [AW-1:0]    wp_nxt;
  logic [AW-1:0]    rd_addr;
  arx_pkg::sample_t q_r;
  logic             qv_r;

  // circular line: wp_r holds the newest sample, lag k sits k slots behind
  assign wp_nxt  = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rd_addr = (wp_r >= rd_off) ? wp_r - rd_off : wp_r + AW'(DEPTH) - rd_off;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        wp_r          <= wp_nxt;
        vld_r[wp_nxt] <= 1'b1;
      end
      if (rd_en) qv_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_nxt] <= wr_data;
    if (rd_en) q_r <= mem[rd_addr];
  end

  // entries never written since reset read as zero
  assign rd_data = qv_r ? q_r : '0;

endmodule
`default_nettype wire

// ----- rtl/core/arx_mac.sv -----
`default_nettype none
module arx_mac #(
  parameter int NTAPS = arx_pkg::FEEDBACK_TAPS_DEF + arx_pkg::INPUT_TAPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire arx_pkg::ctl_t     ctl,
  input  wire arx_pkg::sample_t  noise,
  input  wire arx_pkg::coef_t    coef,
  input  wire logic              neg,
  input  wire logic              fb_sel,
  input  wire arx_pkg::sample_t  fb_sample,
  input  wire arx_pkg::sample_t  hist_sample,
  output logic                   busy,
  output arx_pkg::out_item_t     result
);

  localparam int ACC_W = arx_pkg::PROD_W + $clog2(NTAPS + 1) + 1;
  localparam int SW    = arx_pkg::SAMPLE_W;
  localparam int FR    = arx_pkg::FRAC;

  logic                           v1_r;
  logic                           v2_r;
  arx_pkg::coef_t                 coef_r;
  logic                           neg1_r;
  logic                           fbsel_r;
  arx_pkg::sample_t               fbs_r;
  logic                           neg2_r;
  logic signed [arx_pkg::PROD_W-1:0] prod_r;
  logic signed [arx_pkg::PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [ACC_W-1:0]        prod_ext;
  logic signed [ACC_W-1:0]        rnd;
  arx_pkg::sample_t               opnd;
  logic [ACC_W-FR-SW:0]           top;
  logic                           fits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.issue;
      v2_r <= v1_r;
    end
  end

  // operand stage lines up with the registered history read
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      coef_r  <= coef;
      neg1_r  <= neg;
      fbsel_r <= fb_sel;
      fbs_r   <= fb_sample;
    end
    if (v1_r) begin
      prod_r <= prod_nxt;
      neg2_r <= neg1_r;
    end
    if (ctl.start) begin
      acc_r <= ACC_W'(noise) <<< FR;
    end else if (v2_r) begin
      acc_r <= neg2_r ? acc_r - prod_ext : acc_r + prod_ext;
    end
  end

  assign opnd     = fbsel_r ? fbs_r : hist_sample;
  assign prod_nxt = opnd * coef_r;
  assign prod_ext = ACC_W'(prod_r);
  assign busy     = v1_r | v2_r;

  // round half up, then clip to 24 bits
  assign rnd  = acc_r + ACC_W'(1 << (FR - 1));
  assign top  = rnd[ACC_W-1:FR+SW-1];
  assign fits = (&top) | ~(|top);

  always_comb begin
    result.saturated = ~fits;
    if (fits) begin
      result.output_value = rnd[FR+SW-1:FR];
    end else if (rnd[ACC_W-1]) begin
      result.output_value = {1'b1, {(SW-1){1'b0}}};
    end else begin
      result.output_value = {1'b0, {(SW-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/arx_seq.sv -----
`default_nettype none
module arx_seq #(
  parameter int NTAPS = arx_pkg::FEEDBACK_TAPS_DEF + arx_pkg::INPUT_TAPS_DEF,
  parameter int TAP_W = 3
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            pipe_busy,
  input  wire logic            out_free,
  output logic                 in_ready,
  output arx_pkg::ctl_t        ctl,
  output logic [TAP_W-1:0]     tap
);

  arx_pkg::state_t  state_r;
  arx_pkg::state_t  state_nxt;
  logic [TAP_W-1:0] tap_r;
  logic             last;

  assign last = (tap_r == TAP_W'(NTAPS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arx_pkg::ST_IDLE:  if (in_valid) state_nxt = arx_pkg::ST_ISSUE;
      arx_pkg::ST_ISSUE: if (last) state_nxt = arx_pkg::ST_DRAIN;
      arx_pkg::ST_DRAIN: if (!pipe_busy && out_free) state_nxt = arx_pkg::ST_IDLE;
      default:           state_nxt = arx_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    ctl.start  = 1'b0;
    ctl.issue  = 1'b0;
    ctl.finish = 1'b0;
    case (state_r)
      arx_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ctl.start = in_valid;
      end
      arx_pkg::ST_ISSUE: ctl.issue = 1'b1;
      arx_pkg::ST_DRAIN: ctl.finish = !pipe_busy && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arx_pkg::ST_IDLE;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctl.start) begin
        tap_r <= '0;
      end else if (ctl.issue && !last) begin
        tap_r <= tap_r + 1'b1;
      end
    end
  end

  assign tap = tap_r;

endmodule
`default_nettype wire

// ----- rtl/core/arx_model_step_core.sv -----
`default_nettype none
// ARX model step. Each accepted input transfer shifts control_value into the control
// history and evaluates one output sample through a single shared 24x18 multiplier
// and accumulator, one tap per cycle: input taps first (controls at input_delay+i,
// input_delay capped at MAX_DELAY), then feedback taps (past outputs, subtracted),
// with noise_sample preloaded into the accumulator. The sum is rounded half up from
// the Q4.14 coefficient scale to the sample scale and clipped to 24 bits; saturated
// flags a clip. An item goes from acceptance to the result register through the
// per-tap issue, the two-stage multiply pipeline and the write-back; in_ch.ready is
// low meanwhile and returns the cycle after the write-back, so a new item is not
// taken before the last one is written back. The write-back waits while the output
// register still holds an untaken result. A new item is taken while the previous
// result still waits in the output register. Both histories read as zero after
// reset; there is no clearing pass. Coefficients and input_delay are written over
// the APB port, register i at byte address 4*i.
module arx_model_step_core #(
  parameter int FEEDBACK_TAPS = arx_pkg::FEEDBACK_TAPS_DEF,
  parameter int INPUT_TAPS    = arx_pkg::INPUT_TAPS_DEF,
  parameter int MAX_DELAY     = arx_pkg::MAX_DELAY_DEF,
  localparam int PAW          = $clog2(4 * (FEEDBACK_TAPS + INPUT_TAPS + 1))
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  arx_in_if.sink                in_ch,
  arx_out_if.source             out_ch,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [PAW-1:0]   paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);

  localparam int NTAPS = FEEDBACK_TAPS + INPUT_TAPS;
  localparam int DEPTH = MAX_DELAY + INPUT_TAPS;
  localparam int HAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TAP_W = $clog2(NTAPS);
  localparam int FBW   = (FEEDBACK_TAPS > 1) ? $clog2(FEEDBACK_TAPS) : 1;
  localparam int IIW   = (INPUT_TAPS > 1) ? $clog2(INPUT_TAPS) : 1;

  arx_pkg::coef_t     fb_coef [FEEDBACK_TAPS];
  arx_pkg::coef_t     in_coef [INPUT_TAPS];
  arx_pkg::delay_t    delay;
  arx_pkg::ctl_t      ctl;
  logic [TAP_W-1:0]   tap;
  logic [TAP_W-1:0]   fb_tap;
  logic [FBW-1:0]     fb_idx;
  logic [IIW-1:0]     in_idx;
  logic               tap_in;
  logic [HAW-1:0]     d_eff;
  logic [HAW-1:0]     rd_off;
  arx_pkg::coef_t     coef;
  arx_pkg::sample_t   hist_sample;
  arx_pkg::sample_t   oh_r [FEEDBACK_TAPS];
  arx_pkg::out_item_t result;
  arx_pkg::out_item_t out_item_r;
  logic               out_vld_r;
  logic               out_free;
  logic               pipe_busy;
  logic               accept;

  arx_regs #(
    .FEEDBACK_TAPS (FEEDBACK_TAPS),
    .INPUT_TAPS    (INPUT_TAPS),
    .PAW           (PAW)
  ) u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fb_coef, .in_coef, .delay
  );

  arx_seq #(
    .NTAPS (NTAPS),
    .TAP_W (TAP_W)
  ) u_seq (
    .clk, .rst_n,
    .in_valid  (in_ch.valid),
    .pipe_busy,
    .out_free,
    .in_ready  (in_ch.ready),
    .ctl,
    .tap
  );

  assign accept = in_ch.valid & in_ch.ready;

  // tap order: input taps, then feedback taps
  assign tap_in = (int'(tap) < INPUT_TAPS);
  assign in_idx = tap[IIW-1:0];
  assign fb_tap = TAP_W'(tap - TAP_W'(INPUT_TAPS));
  assign fb_idx = fb_tap[FBW-1:0];
  assign coef   = tap_in ? in_coef[in_idx] : fb_coef[fb_idx];

  assign d_eff  = (int'(delay) > MAX_DELAY) ? HAW'(MAX_DELAY) : HAW'(delay);
  assign rd_off = d_eff + HAW'(tap);

  arx_hist #(
    .DEPTH (DEPTH),
    .AW    (HAW)
  ) u_hist (
    .clk, .rst_n,
    .wr_en   (accept),
    .wr_data (in_ch.payload.control_value),
    .rd_en   (ctl.issue & tap_in),
    .rd_off,
    .rd_data (hist_sample)
  );

  arx_mac #(
    .NTAPS (NTAPS)
  ) u_mac (
    .clk, .rst_n, .ctl,
    .noise       (in_ch.payload.noise_sample),
    .coef,
    .neg         (!tap_in),
    .fb_sel      (!tap_in),
    .fb_sample   (oh_r[fb_idx]),
    .hist_sample,
    .busy        (pipe_busy),
    .result
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FEEDBACK_TAPS; i++) oh_r[i] <= '0;
    end else if (ctl.finish) begin
      for (int i = FEEDBACK_TAPS - 1; i > 0; i--) oh_r[i] <= oh_r[i-1];
      oh_r[0] <= result.output_value;
    end
  end

  assign out_free = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ctl.finish) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) out_item_r <= result;
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.payload = out_item_r;

  a_accept_issues: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ctl.issue)
    else $error("accepted transfer did not start tap issue");

  a_ready_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !pipe_busy)
    else $error("input ready while multiply pipeline busy");

  a_finish_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |-> (!out_vld_r || out_ch.ready))
    else $error("result written over a pending transfer");

  a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({in_ch.ready, ctl.issue, ctl.finish}))
    else $error("sequencer phases overlap");

endmodule
`default_nettype wire

// ----- tb/sv/arx_model_step_core_tb.sv -----
module arx_model_step_core_tb;

  localparam int FB_TAPS        = arx_pkg::FEEDBACK_TAPS_DEF;
  localparam int IN_TAPS        = arx_pkg::INPUT_TAPS_DEF;
  localparam int DELAY_CAP      = arx_pkg::MAX_DELAY_DEF;
  localparam int HIST_DEPTH     = DELAY_CAP + IN_TAPS;
  localparam int ADDR_W         = $clog2(4 * (FB_TAPS + IN_TAPS + 1));
  localparam int SMP_MAX        = (1 << (arx_pkg::SAMPLE_W - 1)) - 1;
  localparam int SMP_MIN        = -(1 << (arx_pkg::SAMPLE_W - 1));
  localparam int COEF_MAX       = (1 << (arx_pkg::COEF_W - 1)) - 1;
  localparam int COEF_MIN       = -(1 << (arx_pkg::COEF_W - 1));
  localparam int HALF_PERIOD    = 6;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;
  localparam int PHASE_ITEMS    = 190;
  localparam int SETTLE         = 20;

  typedef enum int {
    REG_FB_COEF_1,
    REG_FB_COEF_2,
    REG_FB_COEF_3,
    REG_IN_COEF_1,
    REG_IN_COEF_2,
    REG_IN_COEF_3,
    REG_INPUT_DELAY,
    REG_UNUSED
  } reg_idx_t;

  class arx_output_scoreboard;
    arx_pkg::coef_t    fb_coef [FB_TAPS];
    arx_pkg::coef_t    in_coef [IN_TAPS];
    arx_pkg::delay_t   delay;
    arx_pkg::sample_t  ctrl_hist [HIST_DEPTH];
    arx_pkg::sample_t  out_hist [FB_TAPS];
    arx_pkg::out_item_t expected_outputs [$];
    int errors;
    int results_seen;

    function new();
      foreach (fb_coef[i]) fb_coef[i] = '0;
      foreach (in_coef[i]) in_coef[i] = '0;
      foreach (ctrl_hist[i]) ctrl_hist[i] = '0;
      foreach (out_hist[i]) out_hist[i] = '0;
      delay = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_FB_COEF_1, REG_FB_COEF_2, REG_FB_COEF_3: begin
          fb_coef[int'(idx) - int'(REG_FB_COEF_1)] = val[arx_pkg::COEF_W-1:0];
        end
        REG_IN_COEF_1, REG_IN_COEF_2, REG_IN_COEF_3: begin
          in_coef[int'(idx) - int'(REG_IN_COEF_1)] = val[arx_pkg::COEF_W-1:0];
        end
        REG_INPUT_DELAY: begin
          delay = val[arx_pkg::DELAY_W-1:0];
        end
        default: ;  // no register there, write dropped
      endcase
    endfunction

    // one model step per accepted input transfer
    function void predict_step(arx_pkg::in_item_t item);
      arx_pkg::sample_t u;
      arx_pkg::sample_t n;
      arx_pkg::out_item_t res;
      longint acc;
      longint y;
      int d;
      u = item.control_value;
      n = item.noise_sample;
      for (int i = HIST_DEPTH - 1; i > 0; i--) ctrl_hist[i] = ctrl_hist[i-1];
      ctrl_hist[0] = u;
      d = (int'(delay) > DELAY_CAP) ? DELAY_CAP : int'(delay);
      acc = 0;
      for (int i = 0; i < IN_TAPS; i++)
        acc += longint'(in_coef[i]) * longint'(ctrl_hist[d+i]);
      for (int j = 0; j < FB_TAPS; j++)
        acc -= longint'(fb_coef[j]) * longint'(out_hist[j]);
      acc += longint'(n) * (longint'(1) << arx_pkg::FRAC);
      // round half up to the sample scale (Q4.14 coefficients); arithmetic shift is a floor
      y = (acc + (longint'(1) << (arx_pkg::FRAC - 1))) >>> arx_pkg::FRAC;
      res.saturated = 1'b0;
      if (y > longint'(SMP_MAX)) begin
        y = SMP_MAX;
        res.saturated = 1'b1;
      end else if (y < longint'(SMP_MIN)) begin
        y = SMP_MIN;
        res.saturated = 1'b1;
      end
      res.output_value = arx_pkg::sample_t'(y);
      for (int j = FB_TAPS - 1; j > 0; j--) out_hist[j] = out_hist[j-1];
      out_hist[0] = res.output_value;
      expected_outputs.push_back(res);
    endfunction

    function void check_output(arx_pkg::out_item_t got);
      arx_pkg::out_item_t exp_item;
      results_seen++;
      if (expected_outputs.size() == 0) begin
        $display("%0t unexpected result: actual value %0d sat %0b", $time,
                 got.output_value, got.saturated);
        errors++;
        return;
      end
      exp_item = expected_outputs.pop_front();
      if (got.output_value !== exp_item.output_value) begin
        $display("%0t output_value mismatch: expected %0d actual %0d", $time,
                 exp_item.output_value, got.output_value);
        errors++;
      end
      if (got.saturated !== exp_item.saturated) begin
        $display("%0t saturated mismatch: expected %0b actual %0b", $time,
                 exp_item.saturated, got.saturated);
        errors++;
      end
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  arx_in_if  in_ch ();
  arx_out_if out_ch ();

  arx_output_scoreboard sb;
  bit src_gaps_on;
  bit sink_gaps_on;
  int idle_cycles = 0;

  arx_model_step_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int rand_control();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      case ($urandom_range(0, 4))
        0: return SMP_MAX;
        1: return SMP_MIN;
        2: return 0;
        3: return 1;
        default: return -1;
      endcase
    end
    if (r < 70) return $signed($urandom) >>> 8;
    return int'($urandom_range(0, 131071)) - 65536;
  endfunction

  function automatic int rand_noise();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $signed($urandom) >>> 8;
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  function automatic arx_pkg::in_item_t make_item(int cv, int nv);
    arx_pkg::in_item_t item;
    item.control_value = arx_pkg::sample_t'(cv);
    item.noise_sample  = arx_pkg::sample_t'(nv);
    return item;
  endfunction

  // random junk above the coefficient bits
  function automatic logic [31:0] wide_coef(int c);
    return ($urandom & 32'hFFFC_0000) | (c & 32'h0003_FFFF);
  endfunction

  function automatic logic [31:0] wide_delay(int d);
    return ($urandom & 32'hFFFF_FFF0) | (d & 32'h0000_000F);
  endfunction

  function automatic int extreme_coef();
    case ($urandom_range(0, 2))
      0: return COEF_MAX;
      1: return COEF_MIN;
      default: return 0;
    endcase
  endfunction

  task automatic send_item(arx_pkg::in_item_t item);
    int g;
    g = src_gaps_on ? pick_gap() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= item;
    do @(posedge clk); while (!in_ch.ready);
    sb.predict_step(item);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
  endtask

  task automatic write_config(logic [31:0] fb1, logic [31:0] fb2, logic [31:0] fb3,
                              logic [31:0] in1, logic [31:0] in2, logic [31:0] in3,
                              logic [31:0] dly);
    reg_write(REG_FB_COEF_1, fb1);
    reg_write(REG_FB_COEF_2, fb2);
    reg_write(REG_FB_COEF_3, fb3);
    reg_write(REG_IN_COEF_1, in1);
    reg_write(REG_IN_COEF_2, in2);
    reg_write(REG_IN_COEF_3, in3);
    reg_write(REG_INPUT_DELAY, dly);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_config(int k);
    if (k == 5) begin
      write_config(wide_coef(extreme_coef()), wide_coef(extreme_coef()),
                   wide_coef(extreme_coef()), wide_coef(extreme_coef()),
                   wide_coef(extreme_coef()), wide_coef(extreme_coef()),
                   wide_delay($urandom_range(0, 2) == 0 ? 0 :
                              ($urandom_range(0, 1) == 0 ? DELAY_CAP : 15)));
    end else if (k % 2 == 0) begin
      // small feedback weights keep the loop stable
      write_config(wide_coef(int'($urandom_range(0, 8191)) - 4096),
                   wide_coef(int'($urandom_range(0, 8191)) - 4096),
                   wide_coef(int'($urandom_range(0, 8191)) - 4096),
                   $urandom, $urandom, $urandom, wide_delay($urandom_range(0, 15)));
    end else begin
      write_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_output(out_ch.payload);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("arx_model_step_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, plus long hold-offs mid-phase so the core backs up
  initial begin
    int g;
    int hold_at;
    hold_at = 300;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      g = 0;
      if (sb.results_seen >= hold_at) begin
        g = LONG_HOLD;
        hold_at += 450;
      end else if (sink_gaps_on) begin
        g = pick_gap();
      end
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    sb = new();
    src_gaps_on   = 1'b1;
    sink_gaps_on  = 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst_n         <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset weights are zero: output is just the noise
    send_item(make_item(SMP_MAX, 0));
    drain();

    // all weights at max; the history still holds the sample from the first test
    write_config(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 0);
    send_item(make_item(0, 0));
    send_item(make_item(0, 5));
    send_item(make_item(SMP_MAX, SMP_MAX));
    send_item(make_item(SMP_MIN, SMP_MIN));
    send_item(make_item(SMP_MIN, 0));
    send_item(make_item(1, -1));
    drain();

    // all weights at min, longest delay
    write_config(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, DELAY_CAP);
    send_item(make_item(SMP_MAX, 0));
    send_item(make_item(SMP_MIN, SMP_MAX));
    send_item(make_item(0, SMP_MIN));
    send_item(make_item(1, 1));
    send_item(make_item(-1, 0));
    send_item(make_item(SMP_MAX, SMP_MIN));
    drain();

    // junk in the upper data bits, delay past the cap, write to a hole in the map
    reg_write(REG_UNUSED, 32'h0001_0000);
    write_config(32'hFFFC_1000, 32'h5556_3000, 32'hA5A4_0800, 32'h0F0C_4000,
                 32'hFFFE_2000, 32'h1230_0100, 32'hFFFF_FFFF);
    send_item(make_item(12345, -54321));
    send_item(make_item(SMP_MIN, SMP_MAX));
    send_item(make_item(4194304, 0));
    send_item(make_item(-4194304, 100));
    drain();

    // tiny weight: rounding on the half-LSB boundary
    write_config(0, 0, 0, 1, 0, 0, 0);
    send_item(make_item(8192, 0));
    send_item(make_item(-8192, 0));
    send_item(make_item(-8193, 0));
    send_item(make_item(8191, 0));
    send_item(make_item(24576, 0));
    drain();

    for (int k = 0; k < 6; k++) begin
      src_gaps_on  = (k != 1) && (k != 3);
      sink_gaps_on = (k != 3) && (k != 4);
      random_config(k);
      repeat (PHASE_ITEMS) send_item(make_item(rand_control(), rand_noise()));
      drain();
    end

    if (sb.errors == 0) begin
      $display("arx_model_step_core verification clean");
    end else begin
      $display("arx_model_step_core verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/arx_pkg.sv
rtl/core/arx_in_if.sv
rtl/core/arx_out_if.sv
rtl/core/arx_regs.sv
rtl/core/arx_hist.sv
rtl/core/arx_mac.sv
rtl/core/arx_seq.sv
rtl/core/arx_model_step_core.sv
tb/sv/arx_model_step_core_tb.sv
